@@ rtl/core/ccel_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar clock package
// Shared types, constants and small calendar tables.
// ----------------------------------------------------------------------------
package ccel_pkg;

  localparam int unsigned YearBitsDef = 12;
  localparam int unsigned EpochYear   = 1970;
  localparam int unsigned DivW        = 33;  // dividend and quotient width
  localparam int unsigned DivisorW    = 10;  // widest divisor is 1000
  localparam int unsigned DigitW      = 11;  // quotient digit per step, three per dividend
  localparam int unsigned RecipW      = 29;  // reciprocal width
  localparam int unsigned RecipShift  = 31;  // reciprocals are scaled by 2^31
  localparam int unsigned DayW        = 17;  // pending day count during the walk
  localparam int unsigned ZW          = 33;  // day-number sum for the weekday

  typedef enum logic [3:0] {
    ST_IDLE, ST_MS, ST_SEC, ST_MIN, ST_HOUR, ST_WALK, ST_ZSUM, ST_WDAY, ST_FIN
  } ccel_state_e;

  typedef enum logic [2:0] {
    DIV_MS, DIV_SEC, DIV_MIN, DIV_HOUR, DIV_WDAY
  } ccel_div_e;

  typedef struct packed {
    logic      capture;
    logic      div_start;
    logic      apply;
    ccel_div_e sel;
    logic      walk;
    logic      zsum;
    logic      publish;
  } ccel_cmd_t;

  typedef struct packed {
    logic div_done;
    logic walk_done;
  } ccel_stat_t;

  function automatic logic [DivisorW-1:0] divisor_of(ccel_div_e sel);
    logic [DivisorW-1:0] d;
    unique case (sel)
      DIV_MS:   d = 10'd1000;
      DIV_SEC:  d = 10'd60;
      DIV_MIN:  d = 10'd60;
      DIV_HOUR: d = 10'd24;
      DIV_WDAY: d = 10'd7;
      default:  d = 10'd1000;
    endcase
    return d;
  endfunction

  // Rounded-up 2^31 / divisor; exact for every partial dividend below 2^21.
  function automatic logic [RecipW-1:0] recip_of(ccel_div_e sel);
    logic [RecipW-1:0] r;
    unique case (sel)
      DIV_MS:   r = 29'd2147484;
      DIV_SEC:  r = 29'd35791395;
      DIV_MIN:  r = 29'd35791395;
      DIV_HOUR: r = 29'd89478486;
      DIV_WDAY: r = 29'd306783379;
      default:  r = 29'd2147484;
    endcase
    return r;
  endfunction

  // Length of a non-leap month, month counted from zero.
  function automatic logic [4:0] month_days(logic [3:0] m);
    logic [4:0] d;
    unique case (m)
      4'd1:                      d = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  // Days before the month in a year that starts in March.
  function automatic logic [8:0] march_offset(logic [3:0] m);
    logic [8:0] v;
    unique case (m)
      4'd0:    v = 9'd306;
      4'd1:    v = 9'd337;
      4'd2:    v = 9'd0;
      4'd3:    v = 9'd31;
      4'd4:    v = 9'd61;
      4'd5:    v = 9'd92;
      4'd6:    v = 9'd122;
      4'd7:    v = 9'd153;
      4'd8:    v = 9'd184;
      4'd9:    v = 9'd214;
      4'd10:   v = 9'd245;
      4'd11:   v = 9'd275;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/calendar_clock_with_epoch_load.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar clock with epoch load
// Gregorian date and time kept to the millisecond, advanced by elapsed time
// or loaded from a count of seconds since 1970.
// ----------------------------------------------------------------------------
// Order: an advance runs four divisions (milliseconds, seconds, minutes and
// hours), then the date walk, the day-number sum and the weekday division; an
// epoch load skips the millisecond division.
// Throughput: one item at a time; the next item is taken once the result is
// offered, later while an earlier result is still unread.
// Reset: date and time return to 1970-01-01 00:00:00.000, no result pending.
// ----------------------------------------------------------------------------
// One item flows as follows. The controller captures the item, then runs the
// shared divider to split the carry into milliseconds (advance only), seconds,
// minutes and hours; each division finds three 11-bit quotient digits by
// reciprocal multiplication. The leftover day count is walked one year or
// one month per cycle with the Gregorian leap rules. The year saturates at its
// maximum; carries out of December then only wrap the month. The weekday is
// taken from a day-number sum reduced modulo seven by the same divider, and the
// daylight-saving flag follows from month, day, weekday and hour. A finished
// item waits in the output registers, so a new item can be taken while the
// result is unread.
module calendar_clock_with_epoch_load #(
  parameter int unsigned YEAR_BITS = ccel_pkg::YearBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 op_i,
  input  wire logic [31:0]          elapsed_ms_i,
  input  wire logic [31:0]          epoch_seconds_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [YEAR_BITS-1:0]      year_now_o,
  output logic [3:0]                month_now_o,
  output logic [4:0]                day_now_o,
  output logic [4:0]                hour_now_o,
  output logic [5:0]                minute_now_o,
  output logic [5:0]                second_now_o,
  output logic [9:0]                milli_now_o,
  output logic [2:0]                weekday_o,
  output logic                      summer_time_o
);
  ccel_pkg::ccel_cmd_t  cmd;
  ccel_pkg::ccel_stat_t stat;

  // Sequencer for the divisions, the date walk and the result hand-off.
  ccel_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Time and date registers with the divider and the output registers.
  ccel_dp #(
    .YEAR_BITS (YEAR_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .op_i            (op_i),
    .elapsed_ms_i    (elapsed_ms_i),
    .epoch_seconds_i (epoch_seconds_i),
    .year_now_o      (year_now_o),
    .month_now_o     (month_now_o),
    .day_now_o       (day_now_o),
    .hour_now_o      (hour_now_o),
    .minute_now_o    (minute_now_o),
    .second_now_o    (second_now_o),
    .milli_now_o     (milli_now_o),
    .weekday_o       (weekday_o),
    .summer_time_o   (summer_time_o)
  );
endmodule
`default_nettype wire

@@ rtl/core/ccel_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Constant divider
// Divides by one of a few fixed divisors, one 11-bit quotient digit at a time,
// using a reciprocal multiplication for each digit.
// ----------------------------------------------------------------------------
module ccel_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [ccel_pkg::DivW-1:0]     dividend_i,
  input  wire ccel_pkg::ccel_div_e           sel_i,
  output logic                               done_o,
  output logic [ccel_pkg::DivW-1:0]          quo_o,
  output logic [ccel_pkg::DivisorW-1:0]      rem_o
);
  localparam int unsigned DivW   = ccel_pkg::DivW;
  localparam int unsigned DsrW   = ccel_pkg::DivisorW;
  localparam int unsigned DigW   = ccel_pkg::DigitW;
  localparam int unsigned RcpW   = ccel_pkg::RecipW;
  localparam int unsigned Shift  = ccel_pkg::RecipShift;
  localparam int unsigned CurW   = DsrW + DigW;
  localparam int unsigned ProdW  = CurW + RcpW;
  localparam int unsigned NumDig = DivW / DigW;

  logic                busy_q, busy_d, done_q, done_d, ph_q, ph_d;
  logic [1:0]          cnt_q, cnt_d;
  logic [DivW-1:0]     quo_q, quo_d;
  logic [DsrW-1:0]     rem_q, rem_d, dsr_q, dsr_d;
  logic [RcpW-1:0]     rcp_q, rcp_d;
  logic [DigW-1:0]     dig_q, dig_d;
  logic [CurW-1:0]     cur, back;
  logic [ProdW-1:0]    prod;

  // Partial dividend: running remainder followed by the next dividend digit.
  assign cur  = {rem_q, quo_q[DivW-1 -: DigW]};
  assign prod = ProdW'(cur) * ProdW'(rcp_q);
  assign back = CurW'(dig_q) * CurW'(dsr_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    ph_d   = ph_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    rcp_d  = rcp_q;
    dig_d  = dig_q;
    if (start_i) begin
      busy_d = 1'b1;
      ph_d   = 1'b0;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = ccel_pkg::divisor_of(sel_i);
      rcp_d  = ccel_pkg::recip_of(sel_i);
    end else if (busy_q) begin
      if (!ph_q) begin
        dig_d = prod[Shift +: DigW];
        ph_d  = 1'b1;
      end else begin
        rem_d = DsrW'(cur - back);
        quo_d = {quo_q[DivW-DigW-1:0], dig_q};
        ph_d  = 1'b0;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 2'(NumDig - 1)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      ph_q   <= ph_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    rcp_q <= rcp_d;
    dig_q <= dig_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

@@ rtl/core/ccel_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar clock controller
// Sequences the divisions, the date walk and the weekday for each item.
// ----------------------------------------------------------------------------
module ccel_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 op_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire ccel_pkg::ccel_stat_t stat_i,
  output ccel_pkg::ccel_cmd_t       cmd_o
);
  ccel_pkg::ccel_state_e state_q, state_d;
  logic                  run_q, run_d;
  logic                  out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ccel_pkg::ST_IDLE;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    ccel_pkg::ccel_state_e nxt;
    nxt         = ccel_pkg::ST_IDLE;
    cmd_o       = '0;
    cmd_o.sel   = ccel_pkg::DIV_MS;
    state_d     = state_q;
    run_d       = run_q;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ccel_pkg::ST_MS:   begin cmd_o.sel = ccel_pkg::DIV_MS;   nxt = ccel_pkg::ST_SEC;  end
      ccel_pkg::ST_SEC:  begin cmd_o.sel = ccel_pkg::DIV_SEC;  nxt = ccel_pkg::ST_MIN;  end
      ccel_pkg::ST_MIN:  begin cmd_o.sel = ccel_pkg::DIV_MIN;  nxt = ccel_pkg::ST_HOUR; end
      ccel_pkg::ST_HOUR: begin cmd_o.sel = ccel_pkg::DIV_HOUR; nxt = ccel_pkg::ST_WALK; end
      ccel_pkg::ST_WDAY: begin cmd_o.sel = ccel_pkg::DIV_WDAY; nxt = ccel_pkg::ST_FIN;  end
      default: ;
    endcase
    unique case (state_q)
      ccel_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = op_i ? ccel_pkg::ST_SEC : ccel_pkg::ST_MS;
        end
      end
      ccel_pkg::ST_MS, ccel_pkg::ST_SEC, ccel_pkg::ST_MIN, ccel_pkg::ST_HOUR,
      ccel_pkg::ST_WDAY: begin
        if (!run_q) begin
          cmd_o.div_start = 1'b1;
          run_d = 1'b1;
        end else if (stat_i.div_done) begin
          cmd_o.apply = 1'b1;
          run_d   = 1'b0;
          state_d = nxt;
        end
      end
      ccel_pkg::ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (stat_i.walk_done) begin
          state_d = ccel_pkg::ST_ZSUM;
        end
      end
      ccel_pkg::ST_ZSUM: begin
        cmd_o.zsum = 1'b1;
        state_d = ccel_pkg::ST_WDAY;
      end
      ccel_pkg::ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ccel_pkg::ST_IDLE;
        end
      end
      default: state_d = ccel_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
endmodule
`default_nettype wire

@@ rtl/core/ccel_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar clock datapath
// Time and date registers, carry divider, date walk and output registers.
// ----------------------------------------------------------------------------
module ccel_dp #(
  parameter int unsigned YEAR_BITS = ccel_pkg::YearBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ccel_pkg::ccel_cmd_t  cmd_i,
  output ccel_pkg::ccel_stat_t      stat_o,
  input  wire logic                 op_i,
  input  wire logic [31:0]          elapsed_ms_i,
  input  wire logic [31:0]          epoch_seconds_i,
  output logic [YEAR_BITS-1:0]      year_now_o,
  output logic [3:0]                month_now_o,
  output logic [4:0]                day_now_o,
  output logic [4:0]                hour_now_o,
  output logic [5:0]                minute_now_o,
  output logic [5:0]                second_now_o,
  output logic [9:0]                milli_now_o,
  output logic [2:0]                weekday_o,
  output logic                      summer_time_o
);
  localparam int unsigned DivW  = ccel_pkg::DivW;
  localparam int unsigned DayW  = ccel_pkg::DayW;
  localparam int unsigned ZW    = ccel_pkg::ZW;
  localparam int unsigned Q100W = $clog2((2 ** YEAR_BITS) / 100 + 1);
  localparam int unsigned Q400W = $clog2((2 ** YEAR_BITS) / 400 + 1);
  localparam logic [YEAR_BITS-1:0] YearMax = '1;
  localparam logic [YEAR_BITS-1:0] YearRst = YEAR_BITS'(ccel_pkg::EpochYear);
  localparam logic [Q100W-1:0] Q100Rst = Q100W'(ccel_pkg::EpochYear / 100);
  localparam logic [6:0]       R100Rst = 7'(ccel_pkg::EpochYear % 100);
  localparam logic [Q400W-1:0] Q400Rst = Q400W'(ccel_pkg::EpochYear / 400);
  localparam logic [8:0]       R400Rst = 9'(ccel_pkg::EpochYear % 400);

  // Date and time state.
  logic [YEAR_BITS-1:0] year_q, year_d;
  logic [Q100W-1:0]     q100_q, q100_d;
  logic [6:0]           r100_q, r100_d;
  logic [Q400W-1:0]     q400_q, q400_d;
  logic [8:0]           r400_q, r400_d;
  logic [3:0]           month_q, month_d;
  logic [4:0]           day_q, day_d, hour_q, hour_d;
  logic [5:0]           minute_q, minute_d, second_q, second_d;
  logic [9:0]           milli_q, milli_d;
  logic [2:0]           wday_q, wday_d;
  // Work registers.
  logic [DivW-1:0]      carry_q, carry_d;
  logic [DayW-1:0]      days_q, days_d;

  logic [DivW-1:0]      dividend, quo;
  logic [9:0]           rem, field;
  logic                 div_done;

  ccel_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .sel_i      (cmd_i.sel),
    .done_o     (div_done),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  always_comb begin
    unique case (cmd_i.sel)
      ccel_pkg::DIV_MS:   field = milli_q;
      ccel_pkg::DIV_SEC:  field = {4'd0, second_q};
      ccel_pkg::DIV_MIN:  field = {4'd0, minute_q};
      ccel_pkg::DIV_HOUR: field = {5'd0, hour_q};
      default:            field = '0;
    endcase
  end
  assign dividend = carry_q + {{(DivW-10){1'b0}}, field};

  // Leap-year rule from the running remainders of the year.
  logic        leap, year_step, walk_done, at_max;
  logic [8:0]  ylen;
  logic [4:0]  dim;
  assign at_max = year_q == YearMax;
  assign leap   = (year_q[1:0] == 2'd0) && ((r100_q != 7'd0) || (r400_q == 9'd0));
  assign ylen   = leap ? 9'd366 : 9'd365;
  assign dim    = ccel_pkg::month_days(month_q) + {4'd0, (month_q == 4'd1) && leap};
  assign year_step = (month_q == 4'd0) && (days_q >= DayW'(ylen)) && !at_max;
  assign walk_done = !year_step && (days_q < DayW'(dim));

  // Day number of the current date; January and February count with the year before.
  logic                 jf;
  logic [YEAR_BITS-1:0] ycal;
  logic [Q100W-1:0]     q100y;
  logic [Q400W-1:0]     q400y;
  logic [ZW-1:0]        zsum;
  assign jf    = month_q < 4'd2;
  assign ycal  = year_q - YEAR_BITS'(jf);
  assign q100y = q100_q - Q100W'(jf && (r100_q == 7'd0));
  assign q400y = q400_q - Q400W'(jf && (r400_q == 9'd0));
  assign zsum  = ZW'(ycal) * ZW'(365) + ZW'(ycal >> 2) - ZW'(q100y) + ZW'(q400y)
               + ZW'(ccel_pkg::march_offset(month_q)) + ZW'(day_q);

  always_comb begin
    logic [YEAR_BITS-1:0] yi;
    logic [Q100W-1:0]     qi100;
    logic [6:0]           ri100;
    logic [Q400W-1:0]     qi400;
    logic [8:0]           ri400;
    yi    = year_q + 1'b1;
    qi100 = (r100_q == 7'd99) ? q100_q + 1'b1 : q100_q;
    ri100 = (r100_q == 7'd99) ? 7'd0 : r100_q + 1'b1;
    qi400 = (r400_q == 9'd399) ? q400_q + 1'b1 : q400_q;
    ri400 = (r400_q == 9'd399) ? 9'd0 : r400_q + 1'b1;

    year_d = year_q;  q100_d = q100_q;  r100_d = r100_q;
    q400_d = q400_q;  r400_d = r400_q;  month_d = month_q;
    day_d  = day_q;   hour_d = hour_q;  minute_d = minute_q;
    second_d = second_q;  milli_d = milli_q;  wday_d = wday_q;
    carry_d  = carry_q;   days_d  = days_q;

    if (cmd_i.capture) begin
      if (op_i) begin
        year_d = YearRst;  q100_d = Q100Rst;  r100_d = R100Rst;
        q400_d = Q400Rst;  r400_d = R400Rst;  month_d = '0;  day_d = '0;
        hour_d = '0;  minute_d = '0;  second_d = '0;  milli_d = '0;
        carry_d = {1'b0, epoch_seconds_i};
      end else begin
        carry_d = {1'b0, elapsed_ms_i};
      end
    end

    if (cmd_i.apply) begin
      carry_d = quo;
      unique case (cmd_i.sel)
        ccel_pkg::DIV_MS:   milli_d  = rem;
        ccel_pkg::DIV_SEC:  second_d = rem[5:0];
        ccel_pkg::DIV_MIN:  minute_d = rem[5:0];
        ccel_pkg::DIV_HOUR: begin
          hour_d = rem[4:0];
          days_d = DayW'(day_q) + quo[DayW-1:0];
        end
        default: wday_d = (rem[2:0] > 3'd3) ? rem[2:0] - 3'd4 : rem[2:0] + 3'd3;
      endcase
    end

    if (cmd_i.walk) begin
      priority if (year_step) begin
        days_d = days_q - DayW'(ylen);
        year_d = yi;  q100_d = qi100;  r100_d = ri100;  q400_d = qi400;  r400_d = ri400;
      end else if (walk_done) begin
        day_d = days_q[4:0];
      end else begin
        days_d = days_q - DayW'(dim);
        if (month_q == 4'd11) begin
          month_d = '0;
          if (!at_max) begin
            year_d = yi;  q100_d = qi100;  r100_d = ri100;  q400_d = qi400;  r400_d = ri400;
          end
        end else begin
          month_d = month_q + 1'b1;
        end
      end
    end

    if (cmd_i.zsum) begin
      carry_d = zsum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q <= YearRst;  q100_q <= Q100Rst;  r100_q <= R100Rst;
      q400_q <= Q400Rst;  r400_q <= R400Rst;  month_q <= '0;  day_q <= '0;
      hour_q <= '0;  minute_q <= '0;  second_q <= '0;  milli_q <= '0;
    end else begin
      year_q <= year_d;  q100_q <= q100_d;  r100_q <= r100_d;
      q400_q <= q400_d;  r400_q <= r400_d;  month_q <= month_d;  day_q <= day_d;
      hour_q <= hour_d;  minute_q <= minute_d;  second_q <= second_d;  milli_q <= milli_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    days_q  <= days_d;
    wday_q  <= wday_d;
  end

  // US daylight saving from the second Sunday of March to the first Sunday of November.
  logic              dst;
  logic signed [6:0] sun;
  assign sun = $signed({2'b00, day_q} + 7'd1) - $signed({4'b0000, wday_q});
  always_comb begin
    dst = 1'b0;
    if (month_q < 4'd2 || month_q > 4'd10) begin
      dst = 1'b0;
    end else if (month_q > 4'd2 && month_q < 4'd10) begin
      dst = 1'b1;
    end else if (month_q == 4'd2) begin
      if (sun > 7'sd8) dst = 1'b1;
      else if (sun == 7'sd8) dst = (wday_q != 3'd0) || (hour_q >= 5'd2);
    end else begin
      if (sun < 7'sd1) dst = 1'b1;
      else if (sun <= 7'sd7 && wday_q == 3'd0 && hour_q < 5'd2) dst = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      year_now_o    <= year_q;
      month_now_o   <= month_q + 1'b1;
      day_now_o     <= day_q + 1'b1;
      hour_now_o    <= hour_q;
      minute_now_o  <= minute_q;
      second_now_o  <= second_q;
      milli_now_o   <= milli_q;
      weekday_o     <= wday_q;
      summer_time_o <= dst;
    end
  end

  assign stat_o.div_done  = div_done;
  assign stat_o.walk_done = walk_done;
endmodule
`default_nettype wire

@@ test/calendar_clock_with_epoch_load_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar clock with epoch load testbench
// Drives advance and epoch-load items with bursty timing, predicts the date,
// weekday and daylight-saving flag of each item, and checks every result.
// ----------------------------------------------------------------------------
module calendar_clock_with_epoch_load_tb;

  localparam int unsigned YearBits = ccel_pkg::YearBitsDef;
  localparam int unsigned YearMax  = (1 << YearBits) - 1;
  localparam int unsigned IdleLimit = 20000;

  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_LOAD    = 1'b1;

  typedef struct {
    logic        op;
    logic [31:0] ms;
    logic [31:0] secs;
    bit          drain;  // hold this item back until all results are in
  } clock_item_t;

  typedef struct packed {
    logic [YearBits-1:0] year;
    logic [3:0]          month;
    logic [4:0]          day;
    logic [4:0]          hour;
    logic [5:0]          minute;
    logic [5:0]          second;
    logic [9:0]          milli;
    logic [2:0]          wday;
    logic                dst;
  } stamp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic op_i = 1'b0;
  logic [31:0] elapsed_ms_i = '0;
  logic [31:0] epoch_seconds_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  stamp_t seen;

  calendar_clock_with_epoch_load dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .elapsed_ms_i,
    .epoch_seconds_i, .out_valid_o, .out_ready_i,
    .year_now_o(seen.year), .month_now_o(seen.month), .day_now_o(seen.day),
    .hour_now_o(seen.hour), .minute_now_o(seen.minute), .second_now_o(seen.second),
    .milli_now_o(seen.milli), .weekday_o(seen.wday), .summer_time_o(seen.dst)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  clock_item_t pending_q[$];
  stamp_t      stamp_q[$];
  int unsigned mismatches = 0;
  int unsigned n_adv = 0, n_load = 0, n_dst = 0, n_checked = 0;
  int unsigned idle_cycles = 0;

  // Predicted calendar state; month and day count from zero, as in the block.
  int unsigned cal_year, cal_month, cal_day, cal_hour, cal_min, cal_sec, cal_milli;

  function automatic bit is_leap(int unsigned y);
    if (y % 4 != 0) return 1'b0;
    if (y % 100 != 0) return 1'b1;
    return (y % 400) == 0;
  endfunction

  function automatic int unsigned month_length(int unsigned m, int unsigned y);
    int unsigned lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m == 1) return is_leap(y) ? 29 : 28;
    return lens[m % 12];
  endfunction

  function automatic void clear_calendar();
    cal_year = 1970; cal_month = 0; cal_day = 0;
    cal_hour = 0; cal_min = 0; cal_sec = 0; cal_milli = 0;
  endfunction

  // Walks the day count whole years at a time while in January, otherwise
  // month by month. The year stops at its maximum and only the month wraps.
  function automatic void walk_days(longint unsigned n);
    longint unsigned d;
    int unsigned ylen, dim;
    d = cal_day + n;
    forever begin
      ylen = is_leap(cal_year) ? 366 : 365;
      if (cal_month == 0 && d >= ylen && cal_year < YearMax) begin
        d -= ylen;
        cal_year++;
        continue;
      end
      dim = month_length(cal_month, cal_year);
      if (d < dim) break;
      d -= dim;
      cal_month++;
      if (cal_month >= 12) begin
        cal_month = 0;
        if (cal_year < YearMax) cal_year++;
      end
    end
    cal_day = int'(d);
  endfunction

  function automatic void carry_seconds(longint unsigned s);
    longint unsigned t;
    t = cal_sec + s;
    cal_sec = t % 60;
    t = cal_min + t / 60;
    cal_min = t % 60;
    t = cal_hour + t / 60;
    cal_hour = t % 24;
    walk_days(t / 24);
  endfunction

  function automatic int unsigned weekday_of();
    int unsigned x, y, z;
    x = (cal_month + 10) % 12;
    y = cal_year - x / 10;
    z = 365 * y + y / 4 - y / 100 + y / 400 + (x * 306 + 5) / 10 + cal_day;
    z %= 7;
    return (z > 3) ? z - 4 : z + 3;
  endfunction

  // Daylight saving runs from 02:00 on the second Sunday of March to 02:00
  // on the first Sunday of November.
  function automatic bit dst_of(int unsigned dow);
    int unsigned m;
    int sun;
    m = cal_month + 1;
    sun = int'(cal_day + 1) - int'(dow);
    if (m < 3 || m > 11) return 1'b0;
    if (m > 3 && m < 11) return 1'b1;
    if (m == 3) begin
      if (sun > 8) return 1'b1;
      if (sun == 8) return (dow != 0 || cal_hour >= 2);
      return 1'b0;
    end
    if (sun < 1) return 1'b1;
    return (sun <= 7 && dow == 0 && cal_hour < 2);
  endfunction

  function automatic stamp_t next_stamp(logic op, logic [31:0] ms, logic [31:0] secs);
    longint unsigned t;
    int unsigned dow;
    stamp_t r;
    if (op == OP_LOAD) begin
      clear_calendar();
      carry_seconds(secs);
    end else begin
      t = cal_milli + ms;
      cal_milli = t % 1000;
      carry_seconds(t / 1000);
    end
    dow = weekday_of();
    r.year = cal_year[YearBits-1:0];
    r.month = 4'(cal_month + 1);
    r.day = 5'(cal_day + 1);
    r.hour = 5'(cal_hour);
    r.minute = 6'(cal_min);
    r.second = 6'(cal_sec);
    r.milli = 10'(cal_milli);
    r.wday = 3'(dow);
    r.dst = dst_of(dow);
    return r;
  endfunction

  // Input acceptance, result checking and the watchdog, all on the rising edge.
  always @(posedge clk_i) begin
    stamp_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        stamp_q.push_back(next_stamp(op_i, elapsed_ms_i, epoch_seconds_i));
        if (op_i == OP_LOAD) n_load++; else n_adv++;
      end
      if (out_valid_o && out_ready_i) begin
        if (stamp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", seen);
        end else begin
          want = stamp_q.pop_front();
          n_checked++;
          if (want.dst) n_dst++;
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", want, seen);
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no handshake for %0d cycles", IdleLimit);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // The sender runs in bursts; the receiver follows its own stall pattern.
  int unsigned burst_left = 0, gap_left = 0, rx_mode = 0, rx_count = 0;
  bit took_item = 1'b0;

  always @(posedge clk_i) took_item <= in_valid_i && in_ready_o;

  always @(negedge clk_i) begin
    clock_item_t it;
    bit next_valid;
    if (rst_ni) begin
      next_valid = in_valid_i && !took_item;
      if (!next_valid) begin
        if (took_item && burst_left > 0) burst_left--;
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 400);
        end
        if (gap_left > 0) gap_left--;
        else if (pending_q.size() > 0 &&
                 (!pending_q[0].drain || stamp_q.size() == 0)) begin
          it = pending_q.pop_front();
          op_i <= it.op;
          elapsed_ms_i <= it.ms;
          epoch_seconds_i <= it.secs;
          next_valid = 1'b1;
        end
      end
      in_valid_i <= next_valid;
      rx_count++;
      if (rx_count % 97 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 1) == 1);
        2: out_ready_i <= (rx_count % 8 == 0);
        default: out_ready_i <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  task automatic add_item(logic op, logic [31:0] ms, logic [31:0] secs, bit drain = 1'b0);
    clock_item_t it;
    it.op = op; it.ms = ms; it.secs = secs; it.drain = drain;
    pending_q.push_back(it);
  endtask

  initial begin
    logic [31:0] r_ms;
    clear_calendar();
    // Directed part: reset state, field extremes, leap rules, DST boundaries.
    add_item(OP_ADVANCE, 32'd0, 32'hFFFF_FFFF);
    add_item(OP_ADVANCE, 32'hFFFF_FFFF, 32'd0);
    add_item(OP_LOAD, 32'hFFFF_FFFF, 32'd0);
    add_item(OP_LOAD, 32'd0, 32'hFFFF_FFFF);
    add_item(OP_ADVANCE, 32'hFFFF_FFFF, 32'd0);
    add_item(OP_LOAD, 32'd0, 32'd946684799);     // last second of 1999
    add_item(OP_ADVANCE, 32'd999, 32'd0);
    add_item(OP_ADVANCE, 32'd1, 32'd0);
    add_item(OP_LOAD, 32'd0, 32'd951782400);     // leap day of a 400-year
    add_item(OP_ADVANCE, 32'd86400000, 32'd0);
    add_item(OP_LOAD, 32'd0, 32'd4107542399);    // end of February 2100
    add_item(OP_ADVANCE, 32'd1000, 32'd0);
    add_item(OP_LOAD, 32'd0, 32'd1615687199);    // just before spring forward
    add_item(OP_ADVANCE, 32'd1000, 32'd0);
    add_item(OP_LOAD, 32'd0, 32'd1636250399);    // just before fall back
    add_item(OP_ADVANCE, 32'd1000, 32'd0);
    add_item(OP_LOAD, 32'hFFFF_FFFF, 32'd1615680000, 1'b1);
    add_item(OP_ADVANCE, 32'd3600000, 32'd0);
    add_item(OP_ADVANCE, 32'd3600000, 32'd0);
    // Random part: loads to random dates, then runs of advances of mixed size.
    for (int i = 0; i < 530; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        add_item(OP_LOAD, $urandom, $urandom, (i == 260));
      end else begin
        case ($urandom_range(0, 3))
          0: r_ms = $urandom_range(0, 999);
          1: r_ms = $urandom_range(0, 3_600_000);
          2: r_ms = $urandom_range(0, 864_000_000);
          default: r_ms = $urandom;
        endcase
        add_item(OP_ADVANCE, r_ms, $urandom, (i == 260));
      end
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0);
    @(negedge clk_i);
    wait (!in_valid_i);
    wait (stamp_q.size() == 0);
    repeat (600) @(negedge clk_i);
    $display("covered %0d advances and %0d epoch loads; %0d results checked, %0d in DST",
             n_adv, n_load, n_checked, n_dst);
    if (mismatches == 0 && stamp_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, stamp_q.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
